// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the latency ring tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/klrt_pkg.sv =====
// Package: sizes, codes and controller/datapath link types of the latency ring tracker.
package klrt_pkg;

   localparam int unsigned RING_DEPTH = 2048;
   localparam int unsigned ADDR_W     = $clog2(RING_DEPTH);
   localparam int unsigned FILL_W     = ADDR_W + 1;

   localparam int unsigned KEY_W = 32;
   localparam int unsigned SEC_W = 32;
   localparam int unsigned US_W  = 20;
   localparam int unsigned CNT_W = 32;

   localparam int unsigned ENTRY_W    = KEY_W + SEC_W + US_W;
   localparam int unsigned REQ_DATA_W = ((ENTRY_W + 7) / 8) * 8;
   localparam int unsigned REQ_PAD_W  = REQ_DATA_W - ENTRY_W;
   localparam int unsigned RSP_BODY_W = SEC_W + US_W + CNT_W;
   localparam int unsigned RSP_DATA_W = ((RSP_BODY_W + 7) / 8) * 8;
   localparam int unsigned RSP_PAD_W  = RSP_DATA_W - RSP_BODY_W;

   localparam logic [US_W-1:0] MICROS_PER_SECOND = US_W'(1000000);

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_END   = 1'b1
   } command_type;

   typedef struct packed {
      logic load_req;
      logic search_init;
      logic write_slot;
      logic issue;
      logic calc_hit;
      logic set_miss;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic in_is_end;
      logic more_to_issue;
      logic rd_pending;
      logic rd_hit;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== rtl/keyed_latency_ring_tracker.sv =====
// A start request writes its key and timestamp into the next ring slot; an end request
// searches the ring newest first, one ring slot read per cycle, for up to RING_DEPTH - 1 slots.
// Only one request is in flight; the next is taken once the response is staged, and staging
// waits while the output register holds a response that is not yet taken.
// Reset clears slot pointer, fill count and miss counter; unwritten slots read as zero
// through the fill count, so requests are taken right after reset.
`include "assert_macros.svh"

module keyed_latency_ring_tracker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // key, now_seconds, now_micros, zero pad
   input  logic [klrt_pkg::REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // elapsed_seconds, elapsed_micros, miss_count, zero pad
   output logic [klrt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // found
   output logic [0:0]                      rsp_tuser
);
   import klrt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   klrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   klrt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `ASSERT_IMPL(a_miss_counted, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata[SEC_W+US_W +: CNT_W] != '0, "miss response with zero miss count")
   `ASSERT_IMPL(a_issue_bounded, clock, reset, cmd.issue, status.more_to_issue, "ring read past search length")
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted while one in flight")

endmodule

// ===== rtl/klrt_ctrl.sv =====
// Controller state machine: sequences request intake, ring write, ring search and result hand-off.
module klrt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  klrt_pkg::dp_status_type status,
   output klrt_pkg::ctrl_cmd_type  cmd
);
   import klrt_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_WRITE  = 5'b00010,
      ST_SEARCH = 5'b00100,
      ST_CALC   = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               if (status.in_is_end) begin
                  cmd.search_init = 1'b1;
                  state_in        = ST_SEARCH;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            cmd.write_slot = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_SEARCH: begin
            // check the entry read last cycle while the next read goes out
            if (status.rd_pending && status.rd_hit) begin
               state_in = ST_CALC;
            end else if (status.more_to_issue) begin
               cmd.issue = 1'b1;
            end else if (!status.rd_pending) begin
               cmd.set_miss = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_CALC: begin
            cmd.calc_hit = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/klrt_datapath.sv =====
// Datapath: ring memory, slot pointer, fill count, search walker, elapsed-time math and output register.
module klrt_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  klrt_pkg::ctrl_cmd_type               cmd,
   output klrt_pkg::dp_status_type              status,
   input  logic [klrt_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [0:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [klrt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [0:0]                           rsp_tuser
);
   import klrt_pkg::*;

   function automatic logic [ADDR_W-1:0] prev_slot(input logic [ADDR_W-1:0] idx);
      prev_slot = (idx == '0) ? ADDR_W'(RING_DEPTH - 1) : idx - 1'b1;
   endfunction

   logic [ENTRY_W-1:0] ring_mem [RING_DEPTH];

   // latched request
   logic [KEY_W-1:0] req_key_ff, req_key_in;
   logic [SEC_W-1:0] req_sec_ff, req_sec_in;
   logic [US_W-1:0]  req_us_ff,  req_us_in;

   // ring bookkeeping
   logic [ADDR_W-1:0] next_slot_ff, next_slot_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0]  misses_ff, misses_in;
   logic [CNT_W-1:0]  misses_sat;

   // search walker
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic               rd_pending_ff, rd_pending_in;
   logic               rd_live_ff, rd_live_in;
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [KEY_W-1:0] rd_key;
   logic [SEC_W-1:0] rd_sec;
   logic [US_W-1:0]  rd_us;
   logic             borrow;
   logic [SEC_W-1:0] el_sec;
   logic [US_W-1:0]  el_us;

   // result and output registers
   logic             res_found_ff, res_found_in;
   logic [SEC_W-1:0] res_sec_ff, res_sec_in;
   logic [US_W-1:0]  res_us_ff, res_us_in;
   logic [CNT_W-1:0] res_miss_ff, res_miss_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [SEC_W-1:0] rsp_sec_ff, rsp_sec_in;
   logic [US_W-1:0]  rsp_us_ff, rsp_us_in;
   logic [CNT_W-1:0] rsp_miss_ff, rsp_miss_in;

   // slots never written since reset read as zero
   assign rd_key = rd_live_ff ? rd_data_ff[KEY_W-1:0] : '0;
   assign rd_sec = rd_live_ff ? rd_data_ff[KEY_W +: SEC_W] : '0;
   assign rd_us  = rd_live_ff ? rd_data_ff[KEY_W+SEC_W +: US_W] : '0;

   assign borrow = req_us_ff < rd_us;
   assign el_sec = req_sec_ff - rd_sec - SEC_W'(borrow);
   assign el_us  = req_us_ff + (borrow ? MICROS_PER_SECOND : '0) - rd_us;

   assign misses_sat = (misses_ff == '1) ? misses_ff : misses_ff + 1'b1;

   always_comb begin
      req_key_in    = req_key_ff;
      req_sec_in    = req_sec_ff;
      req_us_in     = req_us_ff;
      next_slot_in  = next_slot_ff;
      fill_in       = fill_ff;
      misses_in     = misses_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      rd_pending_in = cmd.issue;
      rd_live_in    = rd_live_ff;
      res_found_in  = res_found_ff;
      res_sec_in    = res_sec_ff;
      res_us_in     = res_us_ff;
      res_miss_in   = res_miss_ff;

      if (cmd.load_req) begin
         req_key_in = req_tdata[KEY_W-1:0];
         req_sec_in = req_tdata[KEY_W +: SEC_W];
         req_us_in  = req_tdata[KEY_W+SEC_W +: US_W];
      end
      if (cmd.search_init) begin
         ptr_in = prev_slot(next_slot_ff);
         cnt_in = '0;
      end
      if (cmd.issue) begin
         ptr_in     = prev_slot(ptr_ff);
         cnt_in     = cnt_ff + 1'b1;
         rd_live_in = {1'b0, ptr_ff} < fill_ff;
      end
      if (cmd.write_slot) begin
         next_slot_in = (next_slot_ff == ADDR_W'(RING_DEPTH - 1)) ? '0 : next_slot_ff + 1'b1;
         if (fill_ff != FILL_W'(RING_DEPTH)) begin
            fill_in = fill_ff + 1'b1;
         end
         res_found_in = 1'b1;
         res_sec_in   = '0;
         res_us_in    = '0;
         res_miss_in  = misses_ff;
      end
      if (cmd.set_miss) begin
         misses_in    = misses_sat;
         res_found_in = 1'b0;
         res_sec_in   = '0;
         res_us_in    = '0;
         res_miss_in  = misses_sat;
      end
      if (cmd.calc_hit) begin
         res_found_in = 1'b1;
         res_sec_in   = el_sec;
         res_us_in    = el_us;
         res_miss_in  = misses_ff;
      end
   end

   always_comb begin
      rsp_found_in = rsp_found_ff;
      rsp_sec_in   = rsp_sec_ff;
      rsp_us_in    = rsp_us_ff;
      rsp_miss_in  = rsp_miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = res_found_ff;
         rsp_sec_in   = res_sec_ff;
         rsp_us_in    = res_us_ff;
         rsp_miss_in  = res_miss_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_slot) begin
         ring_mem[next_slot_ff] <= {req_us_ff, req_sec_ff, req_key_ff};
      end
      if (cmd.issue) begin
         rd_data_ff <= ring_mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_slot_ff  <= '0;
         fill_ff       <= '0;
         misses_ff     <= '0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         next_slot_ff  <= next_slot_in;
         fill_ff       <= fill_in;
         misses_ff     <= misses_in;
         rd_pending_ff <= rd_pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_key_ff   <= req_key_in;
      req_sec_ff   <= req_sec_in;
      req_us_ff    <= req_us_in;
      ptr_ff       <= ptr_in;
      cnt_ff       <= cnt_in;
      rd_live_ff   <= rd_live_in;
      res_found_ff <= res_found_in;
      res_sec_ff   <= res_sec_in;
      res_us_ff    <= res_us_in;
      res_miss_ff  <= res_miss_in;
      rsp_found_ff <= rsp_found_in;
      rsp_sec_ff   <= rsp_sec_in;
      rsp_us_ff    <= rsp_us_in;
      rsp_miss_ff  <= rsp_miss_in;
   end

   assign status.in_is_end     = (req_tuser[0] == CMD_END);
   assign status.more_to_issue = (cnt_ff != ADDR_W'(RING_DEPTH - 1));
   assign status.rd_pending    = rd_pending_ff;
   assign status.rd_hit        = (rd_key == req_key_ff);
   assign status.rsp_free      = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_miss_ff, rsp_us_ff, rsp_sec_ff};

endmodule
